>>> src/key_press_rate_limiter_macros.svh
// Assertion macros for the key press rate limiter.
`ifndef KEY_PRESS_RATE_LIMITER_MACROS_SVH
`define KEY_PRESS_RATE_LIMITER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define KPRL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define KPRL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/kprl_pkg.sv
// ----------------------------------------------------------------------------
// kprl_pkg
// Types, codes and sizes shared by the key press rate limiter modules.
// ----------------------------------------------------------------------------
package kprl_pkg;

	localparam int NUM_KEYS   = 96;
	localparam int FIRST_KEY  = 32;
	localparam int TIME_BITS  = 32;
	localparam int KEY_W      = $clog2(NUM_KEYS);
	localparam int MS_W       = 10;
	localparam int CNT_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	typedef logic [TIME_BITS-1:0] ms_t;
	typedef logic [KEY_W-1:0]     key_idx_t;

	localparam logic [CFG_IDX_W-1:0] CFG_PAUSED     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MAX   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEYS   = 3'd4;

	typedef enum logic [2:0] {
		EV_PRESS   = 3'd0,
		EV_RELEASE = 3'd1,
		EV_RANGE   = 3'd2,
		EV_REPEAT  = 3'd3,
		EV_HELD    = 3'd4,
		EV_WAIT    = 3'd5,
		EV_BUSY    = 3'd6,
		EV_PAUSED  = 3'd7
	} ev_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RECV,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_OUT0,
		ST_OUT1
	} st_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] char_code;
	} item_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [7:0] key_code;
		logic       last;
	} result_t;

	typedef struct packed {
		logic     clear;
		logic     eval;
		logic     held;
		key_idx_t idx;
	} scan_ctl_t;

	typedef struct packed {
		logic     hit;
		key_idx_t hit_idx;
		logic     best_v;
		key_idx_t best_idx;
		ms_t      best_t;
	} scan_stat_t;

endpackage

>>> src/key_press_rate_limiter.sv
// ----------------------------------------------------------------------------
// key_press_rate_limiter
// A tick runs the hold-time scan through the press start RAM, one key per cycle;
// a key at or past the maximum ends the scan early. A character that finds all
// slots full runs the same scan; other characters give their result without
// it. Busy drops in the cycle after the last result; results cannot be stalled.
// Reset clears all state at once through per-key valid bits; no clearing pass.
// ----------------------------------------------------------------------------
`include "key_press_rate_limiter_macros.svh"

module key_press_rate_limiter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  kprl_pkg::item_t                  item,
	output logic                             result_valid,
	output kprl_pkg::result_t                result,
	input  logic                             cfg_we,
	input  logic [kprl_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [kprl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	kprl_pkg::st_t              state_q, state_d;
	kprl_pkg::ms_t              now_q, last_acc_q, pend_t_q;
	logic                       paused_q;
	logic [kprl_pkg::MS_W-1:0]  guard_q, hmax_q, hmin_q;
	logic [kprl_pkg::CNT_W-1:0] maxk_q, cnt_q, cnt_dec;
	logic [kprl_pkg::NUM_KEYS-1:0] held_q, lrv_q, held_dec;
	logic                       pend_v_q;
	kprl_pkg::key_idx_t         pend_k_q, idx_q, ptr_q, idx_s1, rel_i, in_idx, dec_key;
	logic                       cmd_q, early_q, pipe_s1, held_s1, dec_press;
	logic [7:0]                 code_q;
	kprl_pkg::result_t          res0_q, res1_q;
	logic [1:0]                 nres_q;

	logic [8:0]                 off9;
	logic                       in_range, is_busy;
	kprl_pkg::ms_t              lr_rdata, ps_rdata, prev_ms, ps_wdata;
	logic                       ps_we;
	kprl_pkg::key_idx_t         ps_waddr;
	logic                       rep, full, rel_early, rel_v, pend_go, full_after, other_v;
	logic [2:0]                 other_ev;
	logic [7:0]                 other_code;
	kprl_pkg::scan_ctl_t        scan_ctl;
	kprl_pkg::scan_stat_t       scan_st;

	function automatic logic [7:0] key_of(kprl_pkg::key_idx_t k);
		key_of = 8'(kprl_pkg::FIRST_KEY) + 8'(k);
	endfunction

	assign off9     = {1'b0, item.char_code} - 9'(kprl_pkg::FIRST_KEY);
	assign in_range = (item.char_code >= 8'(kprl_pkg::FIRST_KEY)) &&
		(off9 < 9'(kprl_pkg::NUM_KEYS));
	assign in_idx   = off9[kprl_pkg::KEY_W-1:0];
	assign is_busy  = pend_v_q || (now_q == last_acc_q);

	assign prev_ms  = lrv_q[idx_q] ? lr_rdata : '0;
	assign rep      = (now_q - prev_ms) < kprl_pkg::ms_t'(guard_q);
	assign full     = cnt_q >= maxk_q;

	assign rel_early = early_q && scan_st.best_v && (cnt_q >= maxk_q) &&
		(scan_st.best_t >= kprl_pkg::ms_t'(hmin_q));
	assign rel_v     = scan_st.hit || rel_early;
	assign rel_i     = scan_st.hit ? scan_st.hit_idx : scan_st.best_idx;
	assign cnt_dec   = (rel_v && cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
	assign pend_go   = pend_v_q && (cnt_dec < maxk_q);
	assign full_after = cnt_dec >= maxk_q;
	assign other_v   = cmd_q || pend_go;
	assign dec_press = !paused_q && (cmd_q ? !full_after : pend_go);
	assign dec_key   = cmd_q ? idx_q : pend_k_q;

	always_comb begin
		held_dec = held_q;
		if (rel_v) begin
			held_dec[rel_i] = 1'b0;
		end
		if (dec_press) begin
			held_dec[dec_key] = 1'b1;
		end
	end

	always_comb begin
		if (!cmd_q) begin
			other_ev   = paused_q ? kprl_pkg::EV_PAUSED : kprl_pkg::EV_PRESS;
			other_code = key_of(pend_k_q);
		end else begin
			other_code = code_q;
			if (full_after) begin
				other_ev = kprl_pkg::EV_WAIT;
			end else if (paused_q) begin
				other_ev = kprl_pkg::EV_PAUSED;
			end else begin
				other_ev = kprl_pkg::EV_PRESS;
			end
		end
	end

	always_comb begin
		ps_we    = 1'b0;
		ps_waddr = idx_q;
		ps_wdata = now_q;
		if (state_q == kprl_pkg::ST_RECV && !rep && !held_q[idx_q] && !full && !paused_q) begin
			ps_we = 1'b1;
		end else if (state_q == kprl_pkg::ST_DECIDE && !paused_q) begin
			if (!cmd_q && pend_go) begin
				ps_we    = 1'b1;
				ps_waddr = pend_k_q;
				ps_wdata = pend_t_q;
			end else if (cmd_q && !full_after) begin
				ps_we = 1'b1;
			end
		end
	end

	kprl_ram #(.DEPTH(kprl_pkg::NUM_KEYS), .WIDTH(kprl_pkg::TIME_BITS)) u_lr_ram (
		.clk   (clk),
		.we    (state_q == kprl_pkg::ST_RECV),
		.waddr (idx_q),
		.wdata (now_q),
		.raddr (in_idx),
		.rdata (lr_rdata)
	);

	kprl_ram #(.DEPTH(kprl_pkg::NUM_KEYS), .WIDTH(kprl_pkg::TIME_BITS)) u_ps_ram (
		.clk   (clk),
		.we    (ps_we),
		.waddr (ps_waddr),
		.wdata (ps_wdata),
		.raddr (ptr_q),
		.rdata (ps_rdata)
	);

	assign scan_ctl.clear = (state_q == kprl_pkg::ST_IDLE) || (state_q == kprl_pkg::ST_RECV);
	assign scan_ctl.eval  = pipe_s1 &&
		((state_q == kprl_pkg::ST_SCAN) || (state_q == kprl_pkg::ST_DRAIN));
	assign scan_ctl.held  = held_s1;
	assign scan_ctl.idx   = idx_s1;

	kprl_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.now      (now_q),
		.start_ms (ps_rdata),
		.hold_max (hmax_q),
		.stat     (scan_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kprl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		busy         = 1'b1;
		result_valid = 1'b0;
		result       = res0_q;
		case (state_q)
			kprl_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (!item.cmd) begin
						state_d = kprl_pkg::ST_SCAN;
					end else if (!in_range || is_busy) begin
						state_d = kprl_pkg::ST_OUT0;
					end else begin
						state_d = kprl_pkg::ST_RECV;
					end
				end
			end
			kprl_pkg::ST_RECV: begin
				if (!rep && !held_q[idx_q] && full) begin
					state_d = kprl_pkg::ST_SCAN;
				end else begin
					state_d = kprl_pkg::ST_OUT0;
				end
			end
			kprl_pkg::ST_SCAN: begin
				if (scan_st.hit) begin
					state_d = kprl_pkg::ST_DECIDE;
				end else if (ptr_q == kprl_pkg::KEY_W'(kprl_pkg::NUM_KEYS - 1)) begin
					state_d = kprl_pkg::ST_DRAIN;
				end
			end
			kprl_pkg::ST_DRAIN: begin
				state_d = kprl_pkg::ST_DECIDE;
			end
			kprl_pkg::ST_DECIDE: begin
				state_d = (rel_v || other_v) ? kprl_pkg::ST_OUT0 : kprl_pkg::ST_IDLE;
			end
			kprl_pkg::ST_OUT0: begin
				result_valid = 1'b1;
				state_d = (nres_q == 2'd2) ? kprl_pkg::ST_OUT1 : kprl_pkg::ST_IDLE;
			end
			kprl_pkg::ST_OUT1: begin
				result_valid = 1'b1;
				result       = res1_q;
				state_d      = kprl_pkg::ST_IDLE;
			end
			default: begin
				state_d = kprl_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paused_q <= 1'b0;
			guard_q  <= 10'd60;
			hmax_q   <= 10'd50;
			hmin_q   <= 10'd20;
			maxk_q   <= 3'd6;
		end else if (cfg_we) begin
			case (cfg_idx)
				kprl_pkg::CFG_PAUSED:    paused_q <= cfg_wdata[0];
				kprl_pkg::CFG_REPEAT_MS: guard_q  <= cfg_wdata;
				kprl_pkg::CFG_HOLD_MAX:  hmax_q   <= cfg_wdata;
				kprl_pkg::CFG_HOLD_MIN:  hmin_q   <= cfg_wdata;
				kprl_pkg::CFG_MAX_KEYS:  maxk_q   <= cfg_wdata[kprl_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q      <= '0;
			last_acc_q <= '0;
			held_q     <= '0;
			lrv_q      <= '0;
			cnt_q      <= '0;
			pend_v_q   <= 1'b0;
			pend_k_q   <= '0;
			pend_t_q   <= '0;
			cmd_q      <= 1'b0;
			idx_q      <= '0;
			code_q     <= '0;
			ptr_q      <= '0;
			early_q    <= 1'b0;
			pipe_s1    <= 1'b0;
			held_s1    <= 1'b0;
			idx_s1     <= '0;
			res0_q     <= '0;
			res1_q     <= '0;
			nres_q     <= '0;
		end else begin
			pipe_s1 <= 1'b0;
			case (state_q)
				kprl_pkg::ST_IDLE: begin
					if (start) begin
						cmd_q  <= item.cmd;
						idx_q  <= in_idx;
						code_q <= item.char_code;
						ptr_q  <= '0;
						nres_q <= 2'd1;
						if (!item.cmd) begin
							now_q   <= now_q + 1'b1;
							early_q <= pend_v_q;
						end else if (!in_range) begin
							res0_q <= {kprl_pkg::EV_RANGE, item.char_code, 1'b1};
						end else begin
							res0_q <= {kprl_pkg::EV_BUSY, item.char_code, 1'b1};
						end
					end
				end
				kprl_pkg::ST_RECV: begin
					lrv_q[idx_q] <= 1'b1;
					last_acc_q   <= now_q;
					early_q      <= 1'b1;
					if (rep) begin
						res0_q <= {kprl_pkg::EV_REPEAT, code_q, 1'b1};
					end else if (held_q[idx_q]) begin
						res0_q <= {kprl_pkg::EV_HELD, code_q, 1'b1};
					end else if (!full) begin
						if (paused_q) begin
							res0_q <= {kprl_pkg::EV_PAUSED, code_q, 1'b1};
						end else begin
							res0_q        <= {kprl_pkg::EV_PRESS, code_q, 1'b1};
							held_q[idx_q] <= 1'b1;
							cnt_q         <= cnt_q + 1'b1;
						end
					end
				end
				kprl_pkg::ST_SCAN: begin
					ptr_q   <= ptr_q + 1'b1;
					pipe_s1 <= 1'b1;
					idx_s1  <= ptr_q;
					held_s1 <= held_q[ptr_q];
				end
				kprl_pkg::ST_DECIDE: begin
					cnt_q  <= dec_press ? cnt_dec + 1'b1 : cnt_dec;
					held_q <= held_dec;
					if (!cmd_q) begin
						if (pend_go) begin
							pend_v_q <= 1'b0;
						end
					end else if (full_after) begin
						pend_v_q <= 1'b1;
						pend_k_q <= idx_q;
						pend_t_q <= now_q;
					end
					if (rel_v) begin
						res0_q <= {kprl_pkg::EV_RELEASE, key_of(rel_i), !other_v};
						res1_q <= {other_ev, other_code, 1'b1};
						nres_q <= other_v ? 2'd2 : 2'd1;
					end else begin
						res0_q <= {other_ev, other_code, 1'b1};
						nres_q <= other_v ? 2'd1 : 2'd0;
					end
				end
				default: ;
			endcase
		end
	end

	`KPRL_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted transaction did not raise busy")
	`KPRL_ASSERT_NEXT(a_second_result, result_valid && !result.last, result_valid && result.last, "first of two results not followed by the final one")
	`KPRL_ASSERT_NOW(a_count_match, 1'b1, int'(cnt_q) == $countones(held_q), "held count disagrees with held keys")
	`KPRL_ASSERT_NOW(a_pending_free, pend_v_q, !held_q[pend_k_q], "pending key is already held")

endmodule

>>> src/kprl_ram.sv
// ----------------------------------------------------------------------------
// kprl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kprl_ram #(
	parameter int DEPTH = 96,
	parameter int WIDTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> src/kprl_scan.sv
// ----------------------------------------------------------------------------
// kprl_scan
// Hold-time compare unit: one held key per cycle, records the first key at or past
// the maximum hold time and the longest-held key (lowest index on ties).
// ----------------------------------------------------------------------------
module kprl_scan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kprl_pkg::scan_ctl_t        ctl,
	input  kprl_pkg::ms_t              now,
	input  kprl_pkg::ms_t              start_ms,
	input  logic [kprl_pkg::MS_W-1:0]  hold_max,
	output kprl_pkg::scan_stat_t       stat
);

	kprl_pkg::ms_t      held_t;
	logic               hit_q;
	logic               best_v_q;
	kprl_pkg::key_idx_t hit_idx_q;
	kprl_pkg::key_idx_t best_idx_q;
	kprl_pkg::ms_t      best_t_q;

	assign held_t = now - start_ms;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q      <= 1'b0;
			best_v_q   <= 1'b0;
			hit_idx_q  <= '0;
			best_idx_q <= '0;
			best_t_q   <= '0;
		end else if (ctl.clear) begin
			hit_q    <= 1'b0;
			best_v_q <= 1'b0;
		end else if (ctl.eval && ctl.held && !hit_q) begin
			if (held_t >= kprl_pkg::ms_t'(hold_max)) begin
				hit_q     <= 1'b1;
				hit_idx_q <= ctl.idx;
			end else if (!best_v_q || held_t > best_t_q) begin
				best_v_q   <= 1'b1;
				best_idx_q <= ctl.idx;
				best_t_q   <= held_t;
			end
		end
	end

	assign stat.hit      = hit_q;
	assign stat.hit_idx  = hit_idx_q;
	assign stat.best_v   = best_v_q;
	assign stat.best_idx = best_idx_q;
	assign stat.best_t   = best_t_q;

endmodule

>>> tb/key_press_rate_limiter_tb.sv
// ----------------------------------------------------------------------------
// key_press_rate_limiter_tb
// Drives ticks and characters into the rate limiter, predicts every press,
// release and status event in a behavioral copy of the key tables, and checks
// each result strobe against the oldest prediction, across several register
// settings and sender idling patterns.
// ----------------------------------------------------------------------------
module key_press_rate_limiter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import kprl_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	item_t item = '0;
	logic result_valid;
	result_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	key_press_rate_limiter dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result_valid(result_valid), .result(result), .cfg_we(cfg_we),
		.cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// keyboard state copy
	logic cfg_paused;
	logic [9:0] cfg_repeat, cfg_hold_max, cfg_hold_min;
	logic [2:0] cfg_max_keys;
	ms_t kb_now, kb_last_acc, wait_t;
	ms_t rx_time [NUM_KEYS];
	ms_t down_since [NUM_KEYS];
	logic is_down [NUM_KEYS];
	logic [2:0] down_cnt;
	logic wait_v;
	int wait_key;

	result_t events_due [$];
	int errors = 0;
	int gap_pct = 0;
	int quiet_cycles = 0;

	task automatic report(input string msg);
		$display("tb: mismatch: %s", msg);
		errors++;
	endtask

	function automatic void kb_clear();
		cfg_paused = 1'b0; cfg_repeat = 10'd60; cfg_hold_max = 10'd50;
		cfg_hold_min = 10'd20;
		cfg_max_keys = 3'd6;
		kb_now = '0; kb_last_acc = '0; wait_t = '0; wait_v = 1'b0; wait_key = 0;
		down_cnt = 3'd0;
		for (int i = 0; i < NUM_KEYS; i++) begin
			rx_time[i] = '0; down_since[i] = '0; is_down[i] = 1'b0;
		end
	endfunction

	function automatic void lift(input int i);
		is_down[i] = 1'b0;
		if (down_cnt > 0)
			down_cnt--;
	endfunction

	function automatic bit pick_release(input bit early, output int rel);
		bit found = 0;
		ms_t bt = 0;
		ms_t t;
		int bi = 0;
		rel = 0;
		for (int i = 0; i < NUM_KEYS; i++) begin
			if (is_down[i]) begin
				t = kb_now - down_since[i];
				if (t >= cfg_hold_max) begin
					lift(i);
					rel = i;
					return 1;
				end
				if (!found || t > bt) begin
					found = 1; bt = t; bi = i;
				end
			end
		end
		if (early && found && down_cnt >= cfg_max_keys && bt >= cfg_hold_min) begin
			lift(bi);
			rel = bi;
			return 1;
		end
		return 0;
	endfunction

	function automatic void kb_step(input item_t it);
		result_t evs [$];
		result_t r;
		int rel, idx;
		bit waiting;
		ms_t prev;
		if (!it.cmd) begin
			kb_now = kb_now + 1;
			if (pick_release(wait_v, rel)) begin
				r = '{EV_RELEASE, 8'(rel + FIRST_KEY), 1'b0}; evs.push_back(r);
			end
			if (wait_v && down_cnt < cfg_max_keys) begin
				wait_v = 0;
				if (cfg_paused) begin
					r = '{EV_PAUSED, 8'(wait_key + FIRST_KEY), 1'b0};
				end else begin
					down_since[wait_key] = wait_t;
					is_down[wait_key] = 1;
					down_cnt++;
					r = '{EV_PRESS, 8'(wait_key + FIRST_KEY), 1'b0};
				end
				evs.push_back(r);
			end
		end else if (it.char_code < FIRST_KEY || it.char_code >= FIRST_KEY + NUM_KEYS) begin
			r = '{EV_RANGE, it.char_code, 1'b0}; evs.push_back(r);
		end else if (wait_v || kb_now == kb_last_acc) begin
			r = '{EV_BUSY, it.char_code, 1'b0}; evs.push_back(r);
		end else begin
			idx = it.char_code - FIRST_KEY;
			prev = rx_time[idx];
			kb_last_acc = kb_now;
			rx_time[idx] = kb_now;
			if (kb_now - prev < ms_t'(cfg_repeat)) begin
				r = '{EV_REPEAT, it.char_code, 1'b0}; evs.push_back(r);
			end else if (is_down[idx]) begin
				r = '{EV_HELD, it.char_code, 1'b0}; evs.push_back(r);
			end else begin
				waiting = 0;
				if (down_cnt >= cfg_max_keys) begin
					if (pick_release(1, rel)) begin
						r = '{EV_RELEASE, 8'(rel + FIRST_KEY), 1'b0}; evs.push_back(r);
					end
					if (down_cnt >= cfg_max_keys) begin
						wait_v = 1; wait_key = idx; wait_t = kb_now; waiting = 1;
						r = '{EV_WAIT, it.char_code, 1'b0}; evs.push_back(r);
					end
				end
				if (!waiting) begin
					if (cfg_paused) begin
						r = '{EV_PAUSED, it.char_code, 1'b0};
					end else begin
						down_since[idx] = kb_now; is_down[idx] = 1; down_cnt++;
						r = '{EV_PRESS, it.char_code, 1'b0};
					end
					evs.push_back(r);
				end
			end
		end
		if (evs.size() > 0)
			evs[evs.size() - 1].last = 1'b1;
		foreach (evs[i])
			events_due.push_back(evs[i]);
	endfunction

	always @(posedge clk) begin
		result_t e;
		if (arst_n && result_valid) begin
			if (events_due.size() == 0) begin
				report($sformatf("unexpected event %0d key %0d", result.event_res,
					result.key_code));
			end else begin
				e = events_due.pop_front();
				if (result.event_res !== e.event_res)
					report($sformatf("event_res %0d, want %0d", result.event_res, e.event_res));
				if (result.key_code !== e.key_code)
					report($sformatf("key_code %0d, want %0d", result.key_code, e.key_code));
				if (result.last !== e.last)
					report($sformatf("last %0d, want %0d", result.last, e.last));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send(input logic cmd, input logic [7:0] code);
		item_t it;
		it.cmd = cmd;
		it.char_code = code;
		item <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		kb_step(it);
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic tick();
		send(1'b0, 8'($urandom));
	endtask

	task automatic drain();
		start <= 1'b0;
		while (events_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_PAUSED:    cfg_paused = val[0];
			CFG_REPEAT_MS: cfg_repeat = val[9:0];
			CFG_HOLD_MAX:  cfg_hold_max = val[9:0];
			CFG_HOLD_MIN:  cfg_hold_min = val[9:0];
			CFG_MAX_KEYS:  cfg_max_keys = val[2:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input int p, input int rg, input int hmax, input int hmin,
			input int mk);
		drain();
		write_reg(CFG_PAUSED, p);
		write_reg(CFG_REPEAT_MS, rg);
		write_reg(CFG_HOLD_MAX, hmax);
		write_reg(CFG_HOLD_MIN, hmin);
		write_reg(CFG_MAX_KEYS, mk);
	endtask

	task automatic test_basic_chars();
		send(1'b1, 8'd97);
		tick();
		send(1'b1, 8'd97);
		send(1'b1, 8'd98);
		tick();
		send(1'b1, 8'd97);
		send(1'b1, 8'd0);
		send(1'b1, 8'd31);
		send(1'b1, 8'd128);
		send(1'b1, 8'd255);
		send(1'b1, 8'd127);
		repeat (3) tick();
		send(1'b1, 8'd32);
	endtask

	task automatic test_full_slots();
		set_regs(0, 1, 1000, 3, 1);
		tick();
		send(1'b1, 8'd65);
		tick();
		send(1'b1, 8'd66);
		tick();
		send(1'b1, 8'd67);
		repeat (4) tick();
		drain();
		write_reg(CFG_PAUSED, 1);
		send(1'b1, 8'd68);
		tick();
		send(1'b1, 8'd69);
		repeat (4) tick();
	endtask

	task automatic test_random(input int n, input int gap);
		int keybase;
		gap_pct = gap;
		keybase = $urandom_range(FIRST_KEY, FIRST_KEY + NUM_KEYS - 10);
		repeat (n) begin
			if ($urandom_range(99) < 55)
				tick();
			else if ($urandom_range(99) < 80)
				send(1'b1, 8'(keybase + $urandom_range(9)));
			else
				send(1'b1, 8'($urandom));
		end
		gap_pct = 0;
	endtask

	initial begin
		kb_clear();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_chars();
		test_full_slots();
		set_regs(0, 60, 50, 20, 6);
		test_random(150, 0);
		set_regs(0, 1, 1, 1, 1);
		test_random(150, 55);
		drain();
		set_regs(1, 1000, 1000, 1000, 6);
		test_random(150, 32);
		set_regs(0, 5, 8, 3, 2);
		test_random(150, 55);
		set_regs(0, 10, 4, 12, 3);
		test_random(150, 0);
		drain();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+src
src/kprl_pkg.sv
src/kprl_ram.sv
src/kprl_scan.sv
src/key_press_rate_limiter.sv
tb/key_press_rate_limiter_tb.sv
